[hdl/lprt_pkg.sv]
// Shared types, constants and mask helper for the longest-prefix route table.
`default_nettype none
package lprt_pkg;

   localparam int ROUTE_W         = 32;
   localparam int LEN_W           = 6;
   localparam int PORT_W          = 8;
   localparam int TABLE_DEPTH_DEF = 64;

   localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(32);
   localparam logic [ROUTE_W-1:0] ADDR_ONES = 32'hffff_ffff;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // One stored route
   typedef struct packed {
      logic [ROUTE_W-1:0] destination;
      logic [LEN_W-1:0]   length;
      logic [ROUTE_W-1:0] gateway;
      logic [PORT_W-1:0]  port;
   } entry_type;

   // Running best match of a scan
   typedef struct packed {
      logic      found;
      entry_type best;
   } match_status_type;

   // Top len bits set; len of 0 gives an empty mask, 32 a full one
   function automatic logic [ROUTE_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      prefix_mask = ~(ADDR_ONES >> len);
   endfunction

endpackage
`default_nettype wire

[hdl/lprt_store.sv]
// Route entry memory: one write port, one registered read port.
`default_nettype none
module lprt_store
   import lprt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  wire entry_type                      wr_data,
   input  wire logic                           rd_en,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output entry_type                           rd_data
);

   entry_type route_mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= route_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/lprt_match.sv]
// Prefix compare unit: checks one entry per cycle and keeps the best match.
`default_nettype none
module lprt_match
   import lprt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               clr,
   input  wire logic               upd,
   input  wire logic [ROUTE_W-1:0] key,
   input  wire entry_type          entry,
   output match_status_type        status
);

   logic               found_ff;
   logic               found_in;
   entry_type          best_ff;
   logic [ROUTE_W-1:0] mask;
   logic               hit;
   logic               take;

   // masked compare; later entries win on equal length
   always_comb begin
      mask     = prefix_mask(entry.length);
      hit      = ((key ^ entry.destination) & mask) == '0;
      take     = upd && hit && (!found_ff || (entry.length >= best_ff.length));
      found_in = clr ? 1'b0 : (found_ff || take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // best entry payload, no reset needed
   always_ff @(posedge clock) begin
      if (!clr && take) begin
         best_ff <= entry;
      end
   end

   assign status.found = found_ff;
   assign status.best  = best_ff;

endmodule
`default_nettype wire

[hdl/longest_prefix_route_table_top.sv]
// Top level of the longest-prefix route table: sequencer, entry count and response register.
`default_nettype none
// IPv4 route table with longest-prefix match. A request with func 0 appends a route
// (destination, prefix length saturated to 32, gateway, port) in the next free entry, or
// is rejected with table_full once TABLE_DEPTH routes are stored. A request with func 1
// scans the stored routes and returns the longest matching prefix, the later route winning
// among equal lengths; length 0 is the default route. One request is in work at a time.
// An insert goes from acceptance straight to ST_FINISH. A lookup passes ST_SCAN, where the
// single read port of the route memory feeds the compare unit one entry per cycle, and
// ST_DRAIN, which drains the read pipeline; with an empty table it goes straight to
// ST_FINISH. ST_FINISH loads the response once the output register is free, later while an
// earlier response is held by rsp_stall. The next request is accepted from the cycle
// after the response is loaded, while that response waits in its output register.
// Reset clears the entry count but not the route memory; no clearing pass runs.
module longest_prefix_route_table_top
   import lprt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_func,
   input  wire logic [ROUTE_W-1:0] req_address,
   input  wire logic [LEN_W-1:0]   req_prefix_length,
   input  wire logic [ROUTE_W-1:0] req_gateway,
   input  wire logic [PORT_W-1:0]  req_port_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_hit,
   output logic                    rsp_table_full,
   output logic [ROUTE_W-1:0]      rsp_found_gateway,
   output logic [PORT_W-1:0]       rsp_found_port,
   output logic [ROUTE_W-1:0]      rsp_found_destination,
   output logic [LEN_W-1:0]        rsp_found_length
);

   localparam int AddrW = $clog2(TABLE_DEPTH);
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [CntW-1:0]    cnt_ff;
   logic [AddrW-1:0]   idx_ff;
   logic [ROUTE_W-1:0] key_ff;
   logic               func_ff;
   logic               full_ff;
   logic               rd_vld_ff;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic               rsp_full_ff;
   entry_type          rsp_entry_ff;

   logic               accept;
   logic               is_full;
   logic               last_issue;
   logic               rsp_free;
   logic               rsp_load;
   logic               wr_en;
   entry_type          wr_data;
   entry_type          rd_data;
   match_status_type   status;

   // request acceptance and route write
   always_comb begin
      accept             = req_valid && !req_stall;
      is_full            = (cnt_ff == CntW'(TABLE_DEPTH));
      last_issue         = (CntW'(idx_ff) == (cnt_ff - CntW'(1)));
      rsp_free           = !rsp_valid_ff || !rsp_stall;
      rsp_load           = (state_ff == ST_FINISH) && rsp_free;
      wr_en              = accept && (req_func == FUNC_INSERT) && !is_full;
      wr_data.destination = req_address;
      wr_data.length      = (req_prefix_length > MAX_LEN) ? MAX_LEN : req_prefix_length;
      wr_data.gateway     = req_gateway;
      wr_data.port        = req_port_id;
   end

   lprt_store #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AddrW-1:0]),
      .wr_data (wr_data),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   lprt_match u_match (
      .clock  (clock),
      .reset  (reset),
      .clr    (accept),
      .upd    (rd_vld_ff),
      .key    (key_ff),
      .entry  (rd_data),
      .status (status)
   );

   // sequencer, entry count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= (state_ff == ST_SCAN);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  func_ff <= req_func;
                  full_ff <= is_full;
                  key_ff  <= req_address;
                  idx_ff  <= '0;
                  if (wr_en) begin
                     cnt_ff <= cnt_ff + CntW'(1);
                  end
                  if ((req_func == FUNC_LOOKUP) && (cnt_ff != '0)) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_SCAN: begin
               if (last_issue) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  idx_ff <= idx_ff + AddrW'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  if (func_ff == FUNC_INSERT) begin
                     rsp_hit_ff   <= !full_ff;
                     rsp_full_ff  <= full_ff;
                     rsp_entry_ff <= '0;
                  end else begin
                     rsp_hit_ff   <= status.found;
                     rsp_full_ff  <= 1'b0;
                     rsp_entry_ff <= status.found ? status.best : '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_hit_ff;
   assign rsp_table_full        = rsp_full_ff;
   assign rsp_found_gateway     = rsp_entry_ff.gateway;
   assign rsp_found_port        = rsp_entry_ff.port;
   assign rsp_found_destination = rsp_entry_ff.destination;
   assign rsp_found_length      = rsp_entry_ff.length;

`ifndef SYNTHESIS
   // count never passes the table depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // an accepted insert into a non-full table bumps the count by one
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_INSERT) && !is_full)
         |=> (cnt_ff == $past(cnt_ff) + CntW'(1)))
      else $error("insert did not advance entry count");

   // compare unit only sees data read during a scan
   a_rd_vld: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_SCAN))
      else $error("compare update outside of a scan");

   // a new response is loaded only when the sequencer finishes
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response loaded outside finish state");
`endif

endmodule
`default_nettype wire

[verif/longest_prefix_route_table_top_tb.sv]
// Self-checking testbench for the longest-prefix route table: directed and random requests.
module longest_prefix_route_table_top_tb;
   import lprt_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = DEPTH + 16;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic               hit;
      logic               table_full;
      logic [ROUTE_W-1:0] gateway;
      logic [PORT_W-1:0]  port;
      logic [ROUTE_W-1:0] destination;
      logic [LEN_W-1:0]   length;
   } route_rsp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_func;
   logic [ROUTE_W-1:0] req_address;
   logic [LEN_W-1:0]   req_prefix_length;
   logic [ROUTE_W-1:0] req_gateway;
   logic [PORT_W-1:0]  req_port_id;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_hit;
   logic               rsp_table_full;
   logic [ROUTE_W-1:0] rsp_found_gateway;
   logic [PORT_W-1:0]  rsp_found_port;
   logic [ROUTE_W-1:0] rsp_found_destination;
   logic [LEN_W-1:0]   rsp_found_length;

   // Shadow copy of the route table
   logic [ROUTE_W-1:0] tbl_dest [DEPTH];
   logic [LEN_W-1:0]   tbl_len  [DEPTH];
   logic [ROUTE_W-1:0] tbl_gw   [DEPTH];
   logic [PORT_W-1:0]  tbl_port [DEPTH];
   int                 route_total;

   route_rsp_type pending_responses[$];
   int            mismatches;
   int            req_gap_pct;
   int            rsp_stall_pct;
   int            quiet_cycles;

   longest_prefix_route_table_top #(
      .TABLE_DEPTH(DEPTH)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_func              (req_func),
      .req_address           (req_address),
      .req_prefix_length     (req_prefix_length),
      .req_gateway           (req_gateway),
      .req_port_id           (req_port_id),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hit               (rsp_hit),
      .rsp_table_full        (rsp_table_full),
      .rsp_found_gateway     (rsp_found_gateway),
      .rsp_found_port        (rsp_found_port),
      .rsp_found_destination (rsp_found_destination),
      .rsp_found_length      (rsp_found_length)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Top len bits set
   function automatic logic [ROUTE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      if (len == '0) return '0;
      if (len >= MAX_LEN) return ADDR_ONES;
      return ADDR_ONES << (ROUTE_W - len);
   endfunction

   // Expected response of one request; updates the shadow table on insert
   function automatic route_rsp_type predict_route_response(input logic func,
                                                            input logic [ROUTE_W-1:0] addr,
                                                            input logic [LEN_W-1:0] plen,
                                                            input logic [ROUTE_W-1:0] gw,
                                                            input logic [PORT_W-1:0] port);
      route_rsp_type      r;
      logic               found;
      int                 best;
      int                 i;
      logic [LEN_W-1:0]   best_len;
      logic [ROUTE_W-1:0] m;
      r        = '0;
      found    = 1'b0;
      best     = 0;
      best_len = '0;
      if (func == FUNC_INSERT) begin
         if (route_total >= DEPTH) begin
            r.table_full = 1'b1;
         end else begin
            tbl_dest[route_total] = addr;
            tbl_len[route_total]  = (plen > MAX_LEN) ? MAX_LEN : plen;
            tbl_gw[route_total]   = gw;
            tbl_port[route_total] = port;
            route_total++;
            r.hit = 1'b1;
         end
      end else begin
         for (i = 0; i < route_total; i++) begin
            m = len_mask(tbl_len[i]);
            // later route wins on equal length
            if ((addr & m) == (tbl_dest[i] & m) && (!found || tbl_len[i] >= best_len)) begin
               found    = 1'b1;
               best     = i;
               best_len = tbl_len[i];
            end
         end
         if (found) begin
            r.hit         = 1'b1;
            r.gateway     = tbl_gw[best];
            r.port        = tbl_port[best];
            r.destination = tbl_dest[best];
            r.length      = tbl_len[best];
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [ROUTE_W-1:0] exp_val,
                                       input logic [ROUTE_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   // Response checker
   always @(posedge clock) begin
      route_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none actual hit %0h full %0h gw %0h",
                     $time, rsp_hit, rsp_table_full, rsp_found_gateway);
            mismatches++;
         end else begin
            e = pending_responses.pop_front();
            check_field("hit", ROUTE_W'(e.hit), ROUTE_W'(rsp_hit));
            check_field("table_full", ROUTE_W'(e.table_full), ROUTE_W'(rsp_table_full));
            check_field("found_gateway", e.gateway, rsp_found_gateway);
            check_field("found_port", ROUTE_W'(e.port), ROUTE_W'(rsp_found_port));
            check_field("found_destination", e.destination, rsp_found_destination);
            check_field("found_length", ROUTE_W'(e.length), ROUTE_W'(rsp_found_length));
         end
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            req_gap_pct = 0;  rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            req_gap_pct = 54; rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            req_gap_pct = 0;  rsp_stall_pct = 54;
         end
         default: begin
            req_gap_pct = 33; rsp_stall_pct = 33;
         end
      endcase
   endtask

   // Send one request; entered and left at a falling edge
   task automatic send_route_request(input logic func, input logic [ROUTE_W-1:0] addr,
                                     input logic [LEN_W-1:0] plen,
                                     input logic [ROUTE_W-1:0] gw,
                                     input logic [PORT_W-1:0] port);
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_address       <= addr;
      req_prefix_length <= plen;
      req_gateway       <= gw;
      req_port_id       <= port;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_responses.insert(pending_responses.size(),
                               predict_route_response(func, addr, plen, gw, port));
      @(negedge clock);
   endtask

   // Random request: inserts, some near existing prefixes, lookups mostly aimed at stored routes
   task automatic send_random_request();
      logic [ROUTE_W-1:0] addr;
      logic [ROUTE_W-1:0] m;
      logic [LEN_W-1:0]   plen;
      int                 j;
      int                 pick;
      int                 insert_pct;
      insert_pct = (route_total < DEPTH) ? 40 : 10;
      addr       = $urandom;
      if ($urandom_range(99) < insert_pct) begin
         pick = $urandom_range(99);
         if (pick < 8) plen = LEN_W'($urandom_range(63, 33));
         else if (pick < 11) plen = '0;
         else plen = LEN_W'($urandom_range(32, 1));
         if (route_total > 0 && $urandom_range(1) == 1) begin
            j    = $urandom_range(route_total - 1);
            m    = len_mask(LEN_W'($urandom_range(32)));
            addr = (tbl_dest[j] & m) | (addr & ~m);
         end
         send_route_request(FUNC_INSERT, addr, plen, $urandom, PORT_W'($urandom));
      end else begin
         pick = $urandom_range(99);
         if (route_total > 0 && pick < 85) begin
            j    = $urandom_range(route_total - 1);
            m    = len_mask(tbl_len[j]);
            addr = (tbl_dest[j] & m) | (addr & ~m);
            // near miss: flip one bit
            if (pick >= 70) addr = addr ^ (ROUTE_W'(1) << $urandom_range(31));
         end
         send_route_request(FUNC_LOOKUP, addr, LEN_W'($urandom), $urandom, PORT_W'($urandom));
      end
   endtask

   // Lookups on an empty table miss, ignored fields at extremes
   task automatic test_empty_table();
      set_idle_mode(IDLE_NONE);
      send_route_request(FUNC_LOOKUP, '0, '0, '0, '0);
      send_route_request(FUNC_LOOKUP, ADDR_ONES, '1, ADDR_ONES, '1);
      send_route_request(FUNC_LOOKUP, 32'ha5a5_a5a5, 6'd32, 32'h5a5a_5a5a, 8'h5a);
   endtask

   // Nested prefixes, ties, saturation, low destination bits and default routes
   task automatic test_prefix_matching();
      set_idle_mode(IDLE_RECEIVER);
      send_route_request(FUNC_INSERT, 32'h0a00_0000, 6'd8,  32'h0000_0001, 8'h01);
      send_route_request(FUNC_INSERT, 32'h0a01_0000, 6'd16, 32'h0000_0002, 8'h02);
      send_route_request(FUNC_INSERT, 32'h0a01_0203, 6'd32, 32'h0000_0003, 8'hff);
      send_route_request(FUNC_INSERT, 32'h0a01_02ff, 6'd24, 32'h0000_0004, 8'h00);
      send_route_request(FUNC_LOOKUP, 32'h0a01_0203, '0, '0, '0);
      send_route_request(FUNC_LOOKUP, 32'h0a01_02aa, '0, '0, '0);
      send_route_request(FUNC_LOOKUP, 32'h0a01_ffff, '0, '0, '0);
      send_route_request(FUNC_LOOKUP, 32'h0aff_ffff, '0, '0, '0);
      // miss with routes present
      send_route_request(FUNC_LOOKUP, 32'hc0a8_0001, '0, '0, '0);
      // equal length: the later route wins
      send_route_request(FUNC_INSERT, 32'h0a01_0000, 6'd16, 32'h0000_0005, 8'h05);
      send_route_request(FUNC_LOOKUP, 32'h0a01_ffff, '0, '0, '0);
      // lengths above 32 saturate
      send_route_request(FUNC_INSERT, 32'hc0a8_0001, 6'd63, 32'h0000_0006, 8'h06);
      send_route_request(FUNC_LOOKUP, 32'hc0a8_0001, '0, '0, '0);
      send_route_request(FUNC_LOOKUP, 32'hc0a8_0000, '0, '0, '0);
      send_route_request(FUNC_INSERT, ADDR_ONES, 6'd33, ADDR_ONES, 8'hff);
      send_route_request(FUNC_LOOKUP, ADDR_ONES, '0, '0, '0);
      // default routes
      send_route_request(FUNC_INSERT, 32'h1234_5678, 6'd0, 32'h0000_0007, 8'h07);
      send_route_request(FUNC_LOOKUP, 32'hc0a8_0000, '0, '0, '0);
      send_route_request(FUNC_INSERT, 32'h0000_0000, 6'd0, 32'h0000_0008, 8'h08);
      send_route_request(FUNC_LOOKUP, 32'h0000_0000, '0, '0, '0);
      send_route_request(FUNC_LOOKUP, 32'h0a01_0203, '0, '0, '0);
   endtask

   task automatic test_table_fill();
      set_idle_mode(IDLE_BOTH);
      while (route_total < DEPTH) send_random_request();
   endtask

   // Inserts into a full table are rejected and leave it unchanged
   task automatic test_full_table();
      set_idle_mode(IDLE_SENDER);
      send_route_request(FUNC_INSERT, '0, '0, '0, '0);
      send_route_request(FUNC_INSERT, ADDR_ONES, '1, ADDR_ONES, '1);
      send_route_request(FUNC_LOOKUP, '0, '0, '0, '0);
      send_route_request(FUNC_LOOKUP, ADDR_ONES, '0, '0, '0);
   endtask

   task automatic test_random_traffic();
      idle_mode_type mode;
      mode = IDLE_NONE;
      repeat (4) begin
         set_idle_mode(mode);
         repeat (280) send_random_request();
         mode = mode.next();
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = FUNC_INSERT;
      req_address       = '0;
      req_prefix_length = '0;
      req_gateway       = '0;
      req_port_id       = '0;
      rsp_stall         = 1'b0;
      req_gap_pct       = 0;
      rsp_stall_pct     = 0;
      route_total       = 0;
      mismatches        = 0;
      quiet_cycles      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_prefix_matching();
      test_table_fill();
      test_full_table();
      test_random_traffic();

      req_valid <= 1'b0;
      set_idle_mode(IDLE_NONE);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hdl/lprt_pkg.sv
hdl/lprt_store.sv
hdl/lprt_match.sv
hdl/longest_prefix_route_table_top.sv
verif/longest_prefix_route_table_top_tb.sv
